// File: src/nrsp_pkg.sv
// ----------------------------------------------------------------------------
// nrsp_pkg
// Shared constants, types and helpers of the nearest ray-sphere pick block.
// ----------------------------------------------------------------------------
package nrsp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ID_BITS   = 16;
   localparam int DIST_W    = 31;
   localparam int CSR_IDX_W = 3;

   localparam logic [31:0] TENTH_Q = 32'(((1 << FRAC_BITS) + 5) / 10);

   // Square root works on disc shifted up by FRAC_BITS, two bits per step.
   localparam int SQ_STEPS = (32 + FRAC_BITS + 1) / 2;
   localparam int SQ_W     = 2 * SQ_STEPS;
   // Divider works on the numerator shifted up by FRAC_BITS, one bit per step.
   localparam int DIV_W    = 32 + FRAC_BITS;
   localparam int CNT_W    = $clog2(DIV_W + 1);

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SEL_ID   = 3'd6;

   typedef struct packed {
      logic [ID_BITS-1:0] obj_tag;
      logic               probe;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [DIST_W-1:0]  radius;
      logic               last_object;
   } item_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic [ID_BITS-1:0] selected_id;
   } ray_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: src/nrsp_front.sv
// ----------------------------------------------------------------------------
// nrsp_front
// Classifies an incoming record and works out its pick radius.
// ----------------------------------------------------------------------------
module nrsp_front (
   input  logic [nrsp_pkg::ID_BITS-1:0] obj_tag,
   input  logic                         usable,
   input  logic signed [31:0]           center_x,
   input  logic signed [31:0]           center_y,
   input  logic signed [31:0]           center_z,
   input  logic                         has_radius,
   input  logic [nrsp_pkg::DIST_W-1:0]  pick_radius,
   input  logic signed [31:0]           scale_x,
   input  logic signed [31:0]           scale_y,
   input  logic signed [31:0]           scale_z,
   input  logic                         last_object,
   output nrsp_pkg::item_type           item
);

   logic [31:0] abs_x, abs_y, abs_z, max_xy, max_xyz, max_all;
   logic [33:0] scaled;

   always_comb begin
      abs_x   = scale_x[31] ? 32'(-scale_x) : 32'(scale_x);
      abs_y   = scale_y[31] ? 32'(-scale_y) : 32'(scale_y);
      abs_z   = scale_z[31] ? 32'(-scale_z) : 32'(scale_z);
      max_xy  = (abs_x > abs_y) ? abs_x : abs_y;
      max_xyz = (max_xy > abs_z) ? max_xy : abs_z;
      max_all = (max_xyz > nrsp_pkg::TENTH_Q) ? max_xyz : nrsp_pkg::TENTH_Q;
      scaled  = ({2'b00, max_all} + {1'b0, max_all, 1'b0}) >> 2;

      item.obj_tag     = obj_tag;
      // Records that cannot be hit skip the arithmetic in the back end.
      item.probe       = usable && (obj_tag != '0);
      item.center_x    = center_x;
      item.center_y    = center_y;
      item.center_z    = center_z;
      item.radius      = has_radius ? pick_radius : scaled[nrsp_pkg::DIST_W-1:0];
      item.last_object = last_object;
   end

endmodule

// File: src/nrsp_queue.sv
// ----------------------------------------------------------------------------
// nrsp_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module nrsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  nrsp_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output nrsp_pkg::item_type head_item
);

   nrsp_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// File: src/nrsp_back.sv
// ----------------------------------------------------------------------------
// nrsp_back
// Runs the ray-sphere test of one word at a time on a shared multiplier, a
// bit-serial square root and a bit-serial divider, and keeps the batch minima.
// ----------------------------------------------------------------------------
module nrsp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  nrsp_pkg::ray_type            ray,
   input  logic                         head_valid,
   input  nrsp_pkg::item_type           head_item,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [nrsp_pkg::ID_BITS-1:0] rsp_picked_id,
   output logic [nrsp_pkg::DIST_W-1:0]  rsp_picked_distance
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_NUM  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   localparam int F = nrsp_pkg::FRAC_BITS;

   logic [2:0] state_ff, state_in;
   nrsp_pkg::item_type item_ff, item_in;
   logic signed [31:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic [3:0] k_ff, k_in;
   logic ph_ff, ph_in;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in, q;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, disc;
   logic signed [31:0] op_a, op_b;
   logic [nrsp_pkg::SQ_W-1:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in, sq_sum;
   logic [nrsp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [nrsp_pkg::DIV_W-1:0] dq_ff, dq_in;
   logic [32:0] rem_ff, rem_in, div_ff, div_in;
   logic [33:0] shifted;
   logic signed [34:0] neg_b, near_num, far_num, root;
   logic hit_ff, hit_in;

   logic [31:0] best_d_ff, best_d_in, sel_d_ff, sel_d_in;
   logic [nrsp_pkg::ID_BITS-1:0] best_o_ff, best_o_in, sel_o_ff, sel_o_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [nrsp_pkg::ID_BITS-1:0] out_id_ff, out_id_in;
   logic [nrsp_pkg::DIST_W-1:0] out_d_ff, out_d_in;
   logic [nrsp_pkg::DIST_W-1:0] hit_dist;
   logic out_free;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_picked_id       = out_id_ff;
   assign rsp_picked_distance = out_d_ff;
   assign out_free            = !rsp_valid_ff || rsp_ready;
   assign pop                 = (state_ff == ST_IDLE) && head_valid;

   // Operands of the shared multiplier, one product per step.
   always_comb begin
      case (k_ff)
         4'd0:    begin op_a = ray.dir_x; op_b = ray.dir_x; end
         4'd1:    begin op_a = ray.dir_y; op_b = ray.dir_y; end
         4'd2:    begin op_a = ray.dir_z; op_b = ray.dir_z; end
         4'd3:    begin op_a = ox_ff;     op_b = ray.dir_x; end
         4'd4:    begin op_a = oy_ff;     op_b = ray.dir_y; end
         4'd5:    begin op_a = oz_ff;     op_b = ray.dir_z; end
         4'd6:    begin op_a = ox_ff;     op_b = ox_ff;     end
         4'd7:    begin op_a = oy_ff;     op_b = oy_ff;     end
         4'd8:    begin op_a = oz_ff;     op_b = oz_ff;     end
         4'd9:    begin op_a = {1'b0, item_ff.radius}; op_b = {1'b0, item_ff.radius}; end
         4'd10:   begin op_a = b_ff;      op_b = b_ff;      end
         default: begin op_a = a_ff;      op_b = c_ff;      end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oz_in    = oz_ff;
      k_in     = k_ff;
      ph_in    = ph_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      hit_in   = hit_ff;
      best_d_in = best_d_ff;
      best_o_in = best_o_ff;
      sel_d_in  = sel_d_ff;
      sel_o_in  = sel_o_ff;
      out_id_in = out_id_ff;
      out_d_in  = out_d_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      q        = prod_ff >>> F;
      disc     = nrsp_pkg::sat32(acc_ff - (q <<< 2));
      sq_sum   = res_ff + bit_ff;
      shifted  = {rem_ff, dq_ff[nrsp_pkg::DIV_W-1]};
      neg_b    = -35'(b_ff);
      root     = 35'($signed({1'b0, res_ff[nrsp_pkg::SQ_STEPS-1:0]}));
      near_num = neg_b - root;
      far_num  = neg_b + root;
      hit_dist = (dq_ff[nrsp_pkg::DIV_W-1:nrsp_pkg::DIST_W] != '0) ? '1
                 : dq_ff[nrsp_pkg::DIST_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               item_in = head_item;
               ox_in   = nrsp_pkg::sat32(64'(ray.origin_x) - 64'(head_item.center_x));
               oy_in   = nrsp_pkg::sat32(64'(ray.origin_y) - 64'(head_item.center_y));
               oz_in   = nrsp_pkg::sat32(64'(ray.origin_z) - 64'(head_item.center_z));
               k_in    = 4'd0;
               ph_in   = 1'b0;
               hit_in  = 1'b0;
               state_in = head_item.probe ? ST_MUL : ST_FIN;
            end
         end
         ST_MUL: begin
            ph_in = ~ph_ff;
            if (!ph_ff) begin
               prod_in = op_a * op_b;
            end else begin
               k_in = k_ff + 4'd1;
               case (k_ff) inside
                  4'd0, 4'd10: acc_in = q;
                  4'd2: begin
                     a_in   = nrsp_pkg::sat32(acc_ff + q);
                     acc_in = '0;
                  end
                  4'd5: begin
                     b_in   = nrsp_pkg::sat32((acc_ff + q) <<< 1);
                     acc_in = '0;
                  end
                  4'd9: begin
                     c_in   = nrsp_pkg::sat32(acc_ff - q);
                     acc_in = '0;
                  end
                  4'd11: begin
                     // A zero direction or a negative discriminant is a miss.
                     if (a_ff <= 0 || disc < 0) begin
                        state_in = ST_FIN;
                     end else begin
                        v_in     = nrsp_pkg::SQ_W'(disc) << F;
                        res_in   = '0;
                        bit_in   = nrsp_pkg::SQ_W'(1) << (nrsp_pkg::SQ_W - 2);
                        cnt_in   = '0;
                        state_in = ST_SQRT;
                     end
                  end
                  default: acc_in = acc_ff + q;
               endcase
            end
         end
         ST_SQRT: begin
            if (v_ff >= sq_sum) begin
               v_in   = v_ff - sq_sum;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == nrsp_pkg::CNT_W'(nrsp_pkg::SQ_STEPS - 1)) begin
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            if (far_num < 0) begin
               state_in = ST_FIN;
            end else begin
               dq_in  = (near_num >= 0) ? {near_num[31:0], F'(0)} : {far_num[31:0], F'(0)};
               rem_in = '0;
               div_in = {a_ff[31:0], 1'b0};
               cnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (shifted >= {1'b0, div_ff}) begin
               rem_in = 33'(shifted - {1'b0, div_ff});
               dq_in  = {dq_ff[nrsp_pkg::DIV_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[32:0];
               dq_in  = {dq_ff[nrsp_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == nrsp_pkg::CNT_W'(nrsp_pkg::DIV_W - 1)) begin
               hit_in   = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (hit_ff) begin
               if (item_ff.obj_tag == ray.selected_id) begin
                  if ({1'b0, hit_dist} < sel_d_ff) begin
                     sel_d_in = {1'b0, hit_dist};
                     sel_o_in = item_ff.obj_tag;
                  end
               end else if ({1'b0, hit_dist} < best_d_ff) begin
                  best_d_in = {1'b0, hit_dist};
                  best_o_in = item_ff.obj_tag;
               end
            end
            if (!item_ff.last_object) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sel_o_in != '0) begin
                  out_id_in = sel_o_in;
                  out_d_in  = sel_d_in[nrsp_pkg::DIST_W-1:0];
               end else if (best_o_in != '0) begin
                  out_id_in = best_o_in;
                  out_d_in  = best_d_in[nrsp_pkg::DIST_W-1:0];
               end else begin
                  out_id_in = '0;
                  out_d_in  = '0;
               end
               best_d_in = '1;
               best_o_in = '0;
               sel_d_in  = '1;
               sel_o_in  = '0;
               state_in  = ST_IDLE;
            end else begin
               // Hold the word until the output register drains.
               best_d_in = best_d_ff;
               best_o_in = best_o_ff;
               sel_d_in  = sel_d_ff;
               sel_o_in  = sel_o_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      oz_ff    <= oz_in;
      k_ff     <= k_in;
      ph_ff    <= ph_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      v_ff     <= v_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      cnt_ff   <= cnt_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      hit_ff   <= hit_in;
      out_id_ff <= out_id_in;
      out_d_ff  <= out_d_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         best_d_ff    <= '1;
         best_o_ff    <= '0;
         sel_d_ff     <= '1;
         sel_o_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         best_d_ff    <= best_d_in;
         best_o_ff    <= best_o_in;
         sel_d_ff     <= sel_d_in;
         sel_o_ff     <= sel_o_in;
      end
   end

endmodule

// File: src/nearest_ray_sphere_pick.sv
// ----------------------------------------------------------------------------
// nearest_ray_sphere_pick
// Picks the nearest sphere hit by a configured ray over a batch of records, preferring the selected id.
// ----------------------------------------------------------------------------
// A word in the back end takes 12 products on the shared 32x32 multiplier,
// each in a multiply and an accumulate phase, 24 square-root steps, 48
// divider steps and the numerator and finish states. A record that is
// unusable or has id zero skips the arithmetic. A two-word queue lets
// the front end accept records while the back end works, and the result
// word waits in an output register. One word leaves per record marked last.
module nearest_ray_sphere_pick (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [nrsp_pkg::ID_BITS-1:0]          req_obj_tag,
   input  logic                                  req_usable,
   input  logic signed [31:0]                    req_center_x,
   input  logic signed [31:0]                    req_center_y,
   input  logic signed [31:0]                    req_center_z,
   input  logic                                  req_has_radius,
   input  logic [nrsp_pkg::DIST_W-1:0]           req_pick_radius,
   input  logic signed [31:0]                    req_scale_x,
   input  logic signed [31:0]                    req_scale_y,
   input  logic signed [31:0]                    req_scale_z,
   input  logic                                  req_last_object,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [nrsp_pkg::ID_BITS-1:0]          rsp_picked_id,
   output logic [nrsp_pkg::DIST_W-1:0]           rsp_picked_distance,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [nrsp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [31:0]                           csr_wdata
);

   nrsp_pkg::ray_type  ray_ff;
   nrsp_pkg::item_type front_item, head_item;
   logic q_full, head_valid, pop;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff.origin_x    <= '0;
         ray_ff.origin_y    <= '0;
         ray_ff.origin_z    <= '0;
         ray_ff.dir_x       <= '0;
         ray_ff.dir_y       <= '0;
         ray_ff.dir_z       <= -(32'sd1 <<< nrsp_pkg::FRAC_BITS);
         ray_ff.selected_id <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            nrsp_pkg::REG_ORIGIN_X: ray_ff.origin_x <= csr_wdata;
            nrsp_pkg::REG_ORIGIN_Y: ray_ff.origin_y <= csr_wdata;
            nrsp_pkg::REG_ORIGIN_Z: ray_ff.origin_z <= csr_wdata;
            nrsp_pkg::REG_DIR_X:    ray_ff.dir_x    <= csr_wdata;
            nrsp_pkg::REG_DIR_Y:    ray_ff.dir_y    <= csr_wdata;
            nrsp_pkg::REG_DIR_Z:    ray_ff.dir_z    <= csr_wdata;
            nrsp_pkg::REG_SEL_ID:
               ray_ff.selected_id <= csr_wdata[nrsp_pkg::ID_BITS-1:0];
            default: ;
         endcase
      end
   end

   nrsp_front u_front (
      .obj_tag     (req_obj_tag),
      .usable      (req_usable),
      .center_x    (req_center_x),
      .center_y    (req_center_y),
      .center_z    (req_center_z),
      .has_radius  (req_has_radius),
      .pick_radius (req_pick_radius),
      .scale_x     (req_scale_x),
      .scale_y     (req_scale_y),
      .scale_z     (req_scale_z),
      .last_object (req_last_object),
      .item        (front_item)
   );

   nrsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !q_full),
      .push_item  (front_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   nrsp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .ray                 (ray_ff),
      .head_valid          (head_valid),
      .head_item           (head_item),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_picked_id       (rsp_picked_id),
      .rsp_picked_distance (rsp_picked_distance)
   );

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams object records through the ray-sphere pick block and checks each
// batch result against a bit-accurate fixed-point model of the pick.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [15:0] obj_tag;
      logic        usable;
      logic [31:0] center_x, center_y, center_z;
      logic        has_radius;
      logic [30:0] pick_radius;
      logic [31:0] scale_x, scale_y, scale_z;
      logic        last_object;
   } record_type;

   typedef struct {
      logic [15:0] picked_id;
      logic [30:0] picked_distance;
   } pick_type;

   // Pick model together with the store of expected batch results.
   class scoreboard_type;
      longint org[3];
      longint dir[3];
      logic [15:0] sel_id;
      logic [31:0] best_dist, sel_dist;
      logic [15:0] best_obj, sel_obj;
      pick_type pending[$];
      int errors;

      function new();
         org = '{0, 0, 0};
         dir = '{0, 0, -65536};
         sel_id = 0;
         errors = 0;
         clear_batch();
      endfunction

      function void clear_batch();
         best_dist = '1;
         sel_dist = '1;
         best_obj = 0;
         sel_obj = 0;
      endfunction

      function void write_reg(logic [nrsp_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
         case (idx)
            nrsp_pkg::REG_ORIGIN_X: org[0] = longint'($signed(data));
            nrsp_pkg::REG_ORIGIN_Y: org[1] = longint'($signed(data));
            nrsp_pkg::REG_ORIGIN_Z: org[2] = longint'($signed(data));
            nrsp_pkg::REG_DIR_X: dir[0] = longint'($signed(data));
            nrsp_pkg::REG_DIR_Y: dir[1] = longint'($signed(data));
            nrsp_pkg::REG_DIR_Z: dir[2] = longint'($signed(data));
            nrsp_pkg::REG_SEL_ID: sel_id = data[15:0];
            default: ;
         endcase
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint fxmul(longint x, longint y);
         return (x * y) >>> nrsp_pkg::FRAC_BITS;
      endfunction

      function longint int_sqrt(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return longint'(res);
      endfunction

      function bit hit_distance(longint cx, longint cy, longint cz, longint r,
                                output logic [31:0] t);
         longint ox, oy, oz, a, b, rr, c, disc, s, nn, nf, num;
         longint unsigned q;
         t = 0;
         ox = clamp32(org[0] - cx);
         oy = clamp32(org[1] - cy);
         oz = clamp32(org[2] - cz);
         a = clamp32(fxmul(dir[0], dir[0]) + fxmul(dir[1], dir[1]) + fxmul(dir[2], dir[2]));
         b = clamp32(2 * (fxmul(ox, dir[0]) + fxmul(oy, dir[1]) + fxmul(oz, dir[2])));
         rr = (r * r) >>> nrsp_pkg::FRAC_BITS;
         c = clamp32(fxmul(ox, ox) + fxmul(oy, oy) + fxmul(oz, oz) - rr);
         if (a <= 0) return 0;
         disc = clamp32(fxmul(b, b) - 4 * fxmul(a, c));
         if (disc < 0) return 0;
         s = int_sqrt(longint'(disc) << nrsp_pkg::FRAC_BITS);
         nn = -b - s;
         nf = -b + s;
         if (nf < 0) return 0;
         num = (nn >= 0) ? nn : nf;
         q = longint'(num << nrsp_pkg::FRAC_BITS) / (a * 2);
         t = (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
         return 1;
      endfunction

      function void note_record(record_type rec);
         longint m, ax, ay, az, r;
         logic [31:0] t;
         pick_type res;
         if (rec.has_radius) begin
            r = longint'(rec.pick_radius);
         end else begin
            m = longint'(nrsp_pkg::TENTH_Q);
            ax = longint'($signed(rec.scale_x));
            ay = longint'($signed(rec.scale_y));
            az = longint'($signed(rec.scale_z));
            if (ax < 0) ax = -ax;
            if (ay < 0) ay = -ay;
            if (az < 0) az = -az;
            if (ax > m) m = ax;
            if (ay > m) m = ay;
            if (az > m) m = az;
            r = (3 * m) >>> 2;
         end
         if (rec.usable && rec.obj_tag != 0 &&
             hit_distance(longint'($signed(rec.center_x)), longint'($signed(rec.center_y)),
                          longint'($signed(rec.center_z)), r, t)) begin
            if (rec.obj_tag == sel_id) begin
               if (t < sel_dist) begin
                  sel_dist = t;
                  sel_obj = rec.obj_tag;
               end
            end else if (t < best_dist) begin
               best_dist = t;
               best_obj = rec.obj_tag;
            end
         end
         if (!rec.last_object) return;
         if (sel_obj != 0) begin
            res.picked_id = sel_obj;
            res.picked_distance = sel_dist[30:0];
         end else if (best_obj != 0) begin
            res.picked_id = best_obj;
            res.picked_distance = best_dist[30:0];
         end else begin
            res.picked_id = 0;
            res.picked_distance = 0;
         end
         pending.push_back(res);
         clear_batch();
      endfunction

      task check_pick(logic [15:0] id, logic [30:0] got_dist);
         pick_type exp_pick;
         if (pending.size() == 0) begin
            report("result word with no batch pending");
            return;
         end
         exp_pick = pending.pop_front();
         if (id !== exp_pick.picked_id)
            report($sformatf("picked_id %0d, want %0d", id, exp_pick.picked_id));
         if (got_dist !== exp_pick.picked_distance)
            report($sformatf("picked_distance %h, want %h", got_dist,
                             exp_pick.picked_distance));
      endtask

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [15:0] req_obj_tag = 0;
   logic req_usable = 0;
   logic signed [31:0] req_center_x = 0, req_center_y = 0, req_center_z = 0;
   logic req_has_radius = 0;
   logic [30:0] req_pick_radius = 0;
   logic signed [31:0] req_scale_x = 0, req_scale_y = 0, req_scale_z = 0;
   logic req_last_object = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [15:0] rsp_picked_id;
   logic [30:0] rsp_picked_distance;
   logic csr_valid = 0;
   logic csr_ready;
   logic [nrsp_pkg::CSR_IDX_W-1:0] csr_index = 0;
   logic [31:0] csr_wdata = 0;

   scoreboard_type board = new();
   bit stimulus_done = 0;
   bit hold_off = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   nearest_ray_sphere_pick uut (.*);

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(3);
      return $urandom_range(40);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(40 * 65536)) - 20 * 65536);
      endcase
   endfunction

   task automatic idle(int n);
      repeat (n) @(posedge clock);
   endtask

   // Valid stays high after acceptance; the caller lowers it before a gap.
   task automatic send_record(record_type rec);
      req_valid <= 1;
      req_obj_tag <= rec.obj_tag;
      req_usable <= rec.usable;
      req_center_x <= rec.center_x;
      req_center_y <= rec.center_y;
      req_center_z <= rec.center_z;
      req_has_radius <= rec.has_radius;
      req_pick_radius <= rec.pick_radius;
      req_scale_x <= rec.scale_x;
      req_scale_y <= rec.scale_y;
      req_scale_z <= rec.scale_z;
      req_last_object <= rec.last_object;
      do @(posedge clock); while (!req_ready);
      board.note_record(rec);
   endtask

   task automatic write_reg(logic [nrsp_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
   endtask

   // Registers change only with the pipeline drained; records not marked last
   // leave no result, so the back end gets time to finish its last one.
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      idle(150);
   endtask

   task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic [15:0] sel);
      drain();
      write_reg(nrsp_pkg::REG_ORIGIN_X, ox);
      write_reg(nrsp_pkg::REG_ORIGIN_Y, oy);
      write_reg(nrsp_pkg::REG_ORIGIN_Z, oz);
      write_reg(nrsp_pkg::REG_DIR_X, dx);
      write_reg(nrsp_pkg::REG_DIR_Y, dy);
      write_reg(nrsp_pkg::REG_DIR_Z, dz);
      write_reg(nrsp_pkg::REG_SEL_ID, {16'd0, sel});
      csr_valid <= 0;
   endtask

   function automatic record_type rand_record(logic [15:0] sel, bit last);
      record_type rec;
      rec.obj_tag = ($urandom_range(3) == 0) ? sel : 16'($urandom_range(8));
      if ($urandom_range(30) == 0) rec.obj_tag = 16'($urandom);
      rec.usable = $urandom_range(7) != 0;
      rec.center_x = rand_coord();
      rec.center_y = rand_coord();
      rec.center_z = rand_coord();
      rec.has_radius = 1'($urandom_range(1));
      rec.pick_radius = ($urandom_range(4) == 0) ? 31'($urandom)
                                                 : 31'($urandom_range(30 * 65536));
      rec.scale_x = rand_coord();
      rec.scale_y = rand_coord();
      rec.scale_z = rand_coord();
      rec.last_object = last;
      return rec;
   endfunction

   task automatic send_batch(logic [15:0] sel, int len, bit no_gaps);
      for (int i = 0; i < len; i++) begin
         int gap;
         send_record(rand_record(sel, i == len - 1));
         gap = no_gaps ? 0 : gap_length();
         if (gap > 0) begin
            req_valid <= 0;
            idle(gap);
         end
      end
   endtask

   initial begin
      record_type rec;
      logic [15:0] sel;
      idle(5);
      reset <= 0;

      // Reset ray: origin at zero looking down -z.
      rec = '{obj_tag: 16'd5, usable: 1, center_x: 0, center_y: 0,
              center_z: -32'sd655360, has_radius: 1, pick_radius: 31'd65536,
              scale_x: 0, scale_y: 0, scale_z: 0, last_object: 0};
      send_record(rec);
      rec.obj_tag = 16'd7; rec.center_z = -32'sd327680; rec.has_radius = 0;
      rec.scale_x = 32'sh80000000; send_record(rec);
      rec.obj_tag = 0; rec.center_z = -32'sd65536; send_record(rec);
      rec.obj_tag = 16'hFFFF; rec.usable = 0; rec.last_object = 1;
      send_record(rec);
      rec = '{obj_tag: 16'd3, usable: 1, center_x: 0, center_y: 0,
              center_z: 32'sd655360, has_radius: 0, pick_radius: 31'h7FFFFFFF,
              scale_x: 32'sd1000, scale_y: -32'sd1, scale_z: 32'sh7FFFFFFF,
              last_object: 1};
      send_record(rec);
      rec.center_z = 32'sd655360; rec.has_radius = 1; rec.pick_radius = 31'd1000;
      send_record(rec);

      // Selected object beats a nearer other; equal distance keeps the first.
      set_ray(0, 0, 32'sd655360, 0, 0, -32'sd65536, 16'd9);
      rec = '{obj_tag: 16'd4, usable: 1, center_x: 0, center_y: 0,
              center_z: 32'sd327680, has_radius: 1, pick_radius: 31'd65536,
              scale_x: 0, scale_y: 0, scale_z: 0, last_object: 0};
      send_record(rec);
      rec.obj_tag = 16'd6; send_record(rec);
      rec.obj_tag = 16'd9; rec.center_z = -32'sd655360; send_record(rec);
      rec.obj_tag = 16'd9; rec.center_z = 0; rec.last_object = 1;
      send_record(rec);
      rec.obj_tag = 16'd4; rec.center_z = 32'sd327680; send_record(rec);

      // Zero direction and tiny direction are misses.
      set_ray(32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 16'hFFFF);
      send_record(rec);
      set_ray(0, 0, 0, 32'd1, 0, 32'd100, 0);
      send_record(rec);
      set_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h80000000, 32'h7FFFFFFF, 16'd1);
      rec.obj_tag = 16'd1; rec.center_x = 32'sh7FFFFFFF; send_record(rec);
      rec.center_x = 32'sh80000000; rec.pick_radius = 31'h7FFFFFFF; send_record(rec);

      for (int phase = 0; phase < 8; phase++) begin
         sel = 16'($urandom_range(8));
         set_ray(rand_coord(), rand_coord(), rand_coord(),
                 32'($signed($urandom_range(4 * 65536)) - 2 * 65536),
                 32'($signed($urandom_range(4 * 65536)) - 2 * 65536),
                 ($urandom_range(9) == 0) ? $urandom : 32'($signed($urandom_range(4 * 65536)) - 2 * 65536),
                 sel);
         if (phase == 3) begin
            // Receiver pauses while records keep arriving back to back.
            hold_off <= 1;
            send_batch(sel, 1, 1);
            send_batch(sel, 1, 1);
            send_batch(sel, 2, 1);
            send_batch(sel, 3, 1);
            hold_off <= 0;
         end
         for (int n = 0; n < 50;) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(1, 6);
            send_batch(sel, len, 0);
            n += len;
         end
      end
      req_valid <= 0;
      stimulus_done = 1;
   end

   // Receiver: random stalls, plus long hold-offs counted here while hold_off is set.
   initial begin
      int wait_n;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 0;
            idle(600);
         end
         wait_n = gap_length();
         if (wait_n > 0) begin
            rsp_ready <= 0;
            idle(wait_n);
         end
         rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_pick(rsp_picked_id, rsp_picked_distance);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int tail;
      tail = 0;
      forever begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
         if (stimulus_done && board.pending.size() == 0) tail++;
         if (tail > 300) begin
            if (board.errors == 0)
               $display("SUCCESS");
            else
               $display("FAILURE");
            $finish;
         end
      end
   end
endmodule

// File: sim.f
src/nrsp_pkg.sv
src/nrsp_front.sv
src/nrsp_queue.sv
src/nrsp_back.sv
src/nearest_ray_sphere_pick.sv
test/testbench.sv
